>>> sv/assert_macros.svh
// Assertion macros shared by the tilt filter RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KTGB_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KTGB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> sv/ktgb_pkg.sv
// Package for the tilt Kalman filter: types, limits, register indexes,
// the arctangent table and saturation helpers. No dependencies.
`timescale 1ns / 1ps

package ktgb_pkg;

    localparam int TAB_IDX_W = 5;
    localparam int TAB_BITS  = 24;

    localparam logic [2:0] REG_STEP_TIME          = 3'd0;
    localparam logic [2:0] REG_PROCESS_NOISE      = 3'd1;
    localparam logic [2:0] REG_MEASUREMENT_NOISE  = 3'd2;
    localparam logic [2:0] REG_GYRO_FULL_SCALE    = 3'd3;
    localparam logic [2:0] REG_INITIAL_COVARIANCE = 3'd4;

    localparam logic CMD_INIT   = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    localparam logic signed [67:0] ANGLE_LIMIT = 68'sd11796480;
    localparam logic signed [67:0] BIAS_LIMIT  = 68'sd131072000;
    localparam logic signed [67:0] SAT_HI      = 68'sd2147483647;
    localparam logic signed [67:0] SAT_LO      = -68'sd2147483648;

    typedef struct packed {
        logic [15:0] step_time;
        logic [23:0] process_noise;
        logic [23:0] measurement_noise;
        logic [10:0] gyro_full_scale;
        logic [23:0] initial_covariance;
    } ktgb_cfg_t;

    typedef struct packed {
        logic        command;
        logic [15:0] gyro_rate;
        logic [24:0] meas;
    } ktgb_job_t;

    // atan(2^-i) in degrees, Q8.24.
    function automatic logic [31:0] atan_q24(input logic [TAB_IDX_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd754974720;
            5'd1:  v = 32'd445687602;
            5'd2:  v = 32'd235489088;
            5'd3:  v = 32'd119537938;
            5'd4:  v = 32'd60000934;
            5'd5:  v = 32'd30029717;
            5'd6:  v = 32'd15018523;
            5'd7:  v = 32'd7509720;
            5'd8:  v = 32'd3754917;
            5'd9:  v = 32'd1877466;
            5'd10: v = 32'd938734;
            5'd11: v = 32'd469367;
            5'd12: v = 32'd234684;
            5'd13: v = 32'd117342;
            5'd14: v = 32'd58671;
            5'd15: v = 32'd29335;
            5'd16: v = 32'd14668;
            5'd17: v = 32'd7334;
            5'd18: v = 32'd3667;
            5'd19: v = 32'd1833;
            5'd20: v = 32'd917;
            5'd21: v = 32'd458;
            5'd22: v = 32'd229;
            5'd23: v = 32'd115;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [67:0] clip(input logic signed [67:0] v,
                                                input logic signed [67:0] lo,
                                                input logic signed [67:0] hi);
        logic signed [67:0] r;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [67:0] r;
        r = clip(v, SAT_LO, SAT_HI);
        return r[31:0];
    endfunction

endpackage

>>> sv/kalman_tilt_with_gyro_bias.sv
// Top level of the two-state tilt and gyro bias Kalman filter.
// Depends on ktgb_pkg, ktgb_cordic, ktgb_filter and assert_macros.svh.
`timescale 1ns / 1ps

// The block takes one beat at a time and is not ready again until its result
// has been moved into the output register. Each beat first runs the
// accelerometer vector through an iterative CORDIC. An init beat then loads
// the state; an update beat runs eleven multiplications on one shared
// multiplier and two gain divisions on a serial divider. A finished result
// waits in the output register, so the next beat can be accepted before the
// previous result has been taken.
module kalman_tilt_with_gyro_bias #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int FRACTION_BITS     = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input beat.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // accel_side[15:0], accel_vertical[31:16], gyro_rate[47:32]
    input  logic        s_tuser,   // command: 0 initialise, 1 update
    // Result beat.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // angle_estimate[24:0], bias_estimate[52:25],
                                   // measured_angle[77:53], zero padding[79:78]
    // Register writes.
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [23:0] cfg_wdata
);
    import ktgb_pkg::*;

    `include "assert_macros.svh"

    localparam logic [1:0] T_IDLE   = 2'd0;
    localparam logic [1:0] T_CORDIC = 2'd1;
    localparam logic [1:0] T_FILT   = 2'd2;
    localparam logic [1:0] T_OUT    = 2'd3;

    logic [1:0]         state_reg;
    ktgb_cfg_t          cfg_reg;
    logic               cmd_reg;
    logic [15:0]        gyro_reg;
    logic               m_tvalid_reg;
    logic [79:0]        m_tdata_reg;

    logic               accept, out_load;
    logic               cordic_done, filt_done;
    logic signed [24:0] cordic_meas;
    logic signed [24:0] tilt;
    logic signed [27:0] bias;
    ktgb_job_t          job;

    assign s_tready = (state_reg == T_IDLE);
    assign accept   = s_tvalid && s_tready;
    // The result register is free when empty or when its beat leaves now.
    assign out_load = (state_reg == T_OUT) && (!m_tvalid_reg || m_tready);

    assign job.command   = cmd_reg;
    assign job.gyro_rate = gyro_reg;
    assign job.meas      = cordic_meas;

    // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_time          <= 16'd1311;
            cfg_reg.process_noise      <= 24'd1311;
            cfg_reg.measurement_noise  <= 24'd262144;
            cfg_reg.gyro_full_scale    <= 11'd250;
            cfg_reg.initial_covariance <= 24'd65536;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_STEP_TIME:          cfg_reg.step_time          <= cfg_wdata[15:0];
                REG_PROCESS_NOISE:      cfg_reg.process_noise      <= cfg_wdata;
                REG_MEASUREMENT_NOISE:  cfg_reg.measurement_noise  <= cfg_wdata;
                REG_GYRO_FULL_SCALE:    cfg_reg.gyro_full_scale    <= cfg_wdata[10:0];
                REG_INITIAL_COVARIANCE: cfg_reg.initial_covariance <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Beat sequencing: CORDIC, then the filter, then the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= T_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            case (state_reg)
                T_IDLE: begin
                    if (accept) begin
                        state_reg <= T_CORDIC;
                    end
                end
                T_CORDIC: begin
                    if (cordic_done) begin
                        state_reg <= T_FILT;
                    end
                end
                T_FILT: begin
                    if (filt_done) begin
                        state_reg <= T_OUT;
                    end
                end
                T_OUT: begin
                    if (out_load) begin
                        state_reg <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg  <= s_tuser;
            gyro_reg <= s_tdata[47:32];
        end
        if (out_load) begin
            m_tdata_reg <= {2'b00, cordic_meas, bias, tilt};
        end
    end

    ktgb_cordic #(
        .ITER (CORDIC_ITERATIONS),
        .FB   (FRACTION_BITS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .side    (s_tdata[15:0]),
        .vert    (s_tdata[31:16]),
        .done    (cordic_done),
        .meas    (cordic_meas)
    );

    ktgb_filter #(
        .FB (FRACTION_BITS)
    ) u_filter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_done),
        .job     (job),
        .cfg     (cfg_reg),
        .done    (filt_done),
        .tilt    (tilt),
        .bias    (bias)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A beat that is taken keeps the block busy in the following cycle.
    `KTGB_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, accept, !s_tready)
    // The units only finish in the phase that waits for them.
    `KTGB_ASSERT_NOW(a_cordic_in_phase, aclk, aresetn, cordic_done, state_reg == T_CORDIC)
    `KTGB_ASSERT_NOW(a_filter_in_phase, aclk, aresetn, filt_done, state_reg == T_FILT)
    // A fresh result only appears after the filter has finished.
    `KTGB_ASSERT_NOW(a_result_from_out, aclk, aresetn, $rose(m_tvalid_reg), $past(state_reg) == T_OUT)

endmodule

>>> sv/ktgb_cordic.sv
// Iterative vectoring CORDIC giving atan2(side, vertical) in degrees, signed Q9.16.
// Depends on ktgb_pkg for the arctangent table and limits.
`timescale 1ns / 1ps

module ktgb_cordic #(
    parameter int ITER = 16,
    parameter int FB   = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [15:0] side,
    input  logic signed [15:0] vert,
    output logic               done,
    output logic signed [24:0] meas
);
    import ktgb_pkg::*;

    localparam int XW = 44;
    localparam int ZW = FB + 10;
    localparam int SH = TAB_BITS - FB;
    localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'sd180 <<< FB);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_RUN  = 2'd1;
    localparam logic [1:0] C_FIN  = 2'd2;

    logic [1:0]             state_reg;
    logic [TAB_IDX_W-1:0]   cnt_reg;
    logic signed [XW-1:0]   x_reg, y_reg;
    logic signed [ZW-1:0]   z_reg, base_reg;
    logic signed [24:0]     meas_reg;
    logic                   done_reg;

    logic signed [16:0]     xs, ys;
    logic signed [ZW-1:0]   base_start;
    logic signed [XW-1:0]   dx, dy;
    logic [33:0]            a_w;
    logic signed [ZW-1:0]   a_z;
    logic signed [ZW-1:0]   res;
    logic signed [63:0]     r64;
    logic signed [67:0]     rclip;

    always_comb begin
        if (vert < 0) begin
            xs = -17'(vert);
            ys = -17'(side);
            base_start = (side >= 0) ? HALF_TURN : -HALF_TURN;
        end else begin
            xs = 17'(vert);
            ys = 17'(side);
            base_start = '0;
        end
        dx    = x_reg >>> cnt_reg;
        dy    = y_reg >>> cnt_reg;
        a_w   = ((34'(atan_q24(cnt_reg)) << 1) + (34'd1 << SH)) >> (SH + 1);
        a_z   = $signed(ZW'(a_w));
        res   = base_reg + z_reg;
        r64   = ((64'(res) <<< 17) + (64'sd1 <<< FB)) >>> (FB + 1);
        rclip = clip(68'(r64), -ANGLE_LIMIT, ANGLE_LIMIT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                C_IDLE: begin
                    if (start) begin
                        state_reg <= C_RUN;
                    end
                end
                C_RUN: begin
                    if (cnt_reg == TAB_IDX_W'(ITER - 1)) begin
                        state_reg <= C_FIN;
                    end
                end
                C_FIN: begin
                    state_reg <= C_IDLE;
                    done_reg  <= 1'b1;
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            C_IDLE: begin
                x_reg    <= XW'(xs) <<< 24;
                y_reg    <= XW'(ys) <<< 24;
                z_reg    <= '0;
                base_reg <= base_start;
                cnt_reg  <= '0;
            end
            C_RUN: begin
                if (y_reg > 0) begin
                    x_reg <= x_reg + dy;
                    y_reg <= y_reg - dx;
                    z_reg <= z_reg + a_z;
                end else if (y_reg < 0) begin
                    x_reg <= x_reg - dy;
                    y_reg <= y_reg + dx;
                    z_reg <= z_reg - a_z;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            C_FIN: begin
                meas_reg <= rclip[24:0];
            end
            default: ;
        endcase
    end

    assign done = done_reg;
    assign meas = meas_reg;

endmodule

>>> sv/ktgb_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// No package dependencies.
`timescale 1ns / 1ps

module ktgb_div #(
    parameter int NB = 48
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NB-1:0] num,
    input  logic [31:0]   den,
    output logic          done,
    output logic [NB-1:0] quot
);
    localparam int CW = $clog2(NB);

    logic          busy_reg, done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NB-1:0] q_reg;
    logic [31:0]   rem_reg, den_reg;
    logic [32:0]   trial;
    logic [33:0]   diff;
    logic          ge;

    always_comb begin
        trial = {rem_reg, q_reg[NB-1]};
        diff  = {1'b0, trial} - {2'b00, den_reg};
        ge    = ~diff[33];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
            cnt_reg <= CW'(NB - 1);
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[31:0] : trial[31:0];
            q_reg   <= {q_reg[NB-2:0], ge};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

>>> sv/ktgb_filter.sv
// Kalman predict and correct sequencer around one shared 33x33 multiplier
// and the serial divider. Depends on ktgb_pkg and ktgb_div.
`timescale 1ns / 1ps

module ktgb_filter #(
    parameter int FB = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  ktgb_pkg::ktgb_job_t job,
    input  ktgb_pkg::ktgb_cfg_t cfg,
    output logic               done,
    output logic signed [24:0] tilt,
    output logic signed [27:0] bias
);
    import ktgb_pkg::*;

    localparam int NB = 32 + FB;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RATE = 4'd1;
    localparam logic [3:0] S_APRI = 4'd2;
    localparam logic [3:0] S_T1   = 4'd3;
    localparam logic [3:0] S_DP11 = 4'd4;
    localparam logic [3:0] S_T2   = 4'd5;
    localparam logic [3:0] S_NSE  = 4'd6;
    localparam logic [3:0] S_DIV0 = 4'd7;
    localparam logic [3:0] S_DIV1 = 4'd8;
    localparam logic [3:0] S_K0E  = 4'd9;
    localparam logic [3:0] S_K1E  = 4'd10;
    localparam logic [3:0] S_K0N0 = 4'd11;
    localparam logic [3:0] S_K0N1 = 4'd12;
    localparam logic [3:0] S_K1N0 = 4'd13;
    localparam logic [3:0] S_K1N1 = 4'd14;
    localparam logic [3:0] S_DONE = 4'd15;

    logic [3:0]         step_reg;
    logic               phase_reg, done_reg;
    logic signed [24:0] tilt_reg;
    logic signed [27:0] bias_reg;
    logic signed [31:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] n00_reg, n01_reg, n10_reg, n11_reg;
    logic signed [31:0] k0_reg, k1_reg, eps_reg;
    logic signed [32:0] rate_reg, dp11_reg, t2_reg;
    logic signed [33:0] apri_reg, t1_reg;
    logic signed [65:0] prod_reg;

    logic signed [32:0] op_a, op_b, d_s, s_w;
    logic signed [65:0] rs16, rsfb;
    logic signed [67:0] clip_w;
    logic signed [31:0] nsel;
    logic [31:0]        mag;
    logic               div_start, div_done;
    logic [NB-1:0]      div_num, div_q;
    logic [31:0]        div_den;

    function automatic logic signed [31:0] gain_sat(input logic [NB-1:0] q, input logic neg);
        logic signed [31:0] k;
        if (q >= NB'(64'd2147483648)) begin
            k = neg ? 32'sh80000000 : 32'sh7fffffff;
        end else begin
            k = neg ? -$signed(q[31:0]) : $signed(q[31:0]);
        end
        return k;
    endfunction

    // Operand selection for the shared multiplier.
    always_comb begin
        d_s  = $signed({17'd0, cfg.step_time});
        op_a = '0;
        op_b = '0;
        case (step_reg)
            S_RATE: begin
                op_a = 33'($signed(job.gyro_rate));
                op_b = $signed({21'd0, cfg.gyro_full_scale, 1'b0});
            end
            S_APRI: begin
                op_a = d_s;
                op_b = rate_reg - 33'(bias_reg);
            end
            S_T1: begin
                op_a = d_s;
                op_b = 33'(p01_reg) + 33'(p10_reg);
            end
            S_DP11: begin
                op_a = d_s;
                op_b = 33'(p11_reg);
            end
            S_T2: begin
                op_a = d_s;
                op_b = dp11_reg;
            end
            S_K0E: begin
                op_a = 33'(k0_reg);
                op_b = 33'(eps_reg);
            end
            S_K1E: begin
                op_a = 33'(k1_reg);
                op_b = 33'(eps_reg);
            end
            S_K0N0: begin
                op_a = 33'(k0_reg);
                op_b = 33'(n00_reg);
            end
            S_K0N1: begin
                op_a = 33'(k0_reg);
                op_b = 33'(n01_reg);
            end
            S_K1N0: begin
                op_a = 33'(k1_reg);
                op_b = 33'(n00_reg);
            end
            S_K1N1: begin
                op_a = 33'(k1_reg);
                op_b = 33'(n01_reg);
            end
            default: ;
        endcase
    end

    // Rounding of the registered product, and the divider operands.
    always_comb begin
        rs16 = (prod_reg + 66'sd32768) >>> 16;
        rsfb = (prod_reg + (66'sd1 <<< (FB - 1))) >>> FB;
        s_w  = 33'(n00_reg) + $signed({9'd0, cfg.measurement_noise});
        if (s_w < 33'sd1) begin
            s_w = 33'sd1;
        end
        nsel      = (step_reg == S_DIV0) ? n00_reg : n10_reg;
        mag       = nsel[31] ? 32'(-nsel) : 32'(nsel);
        div_num   = {mag, FB'(0)};
        div_den   = s_w[31:0];
        div_start = (step_reg == S_DIV0 || step_reg == S_DIV1) && !phase_reg;
        clip_w    = '0;
    end

    ktgb_div #(.NB(NB)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_q)
    );

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= S_IDLE;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
            tilt_reg  <= '0;
            bias_reg  <= '0;
            p00_reg   <= 32'sd65536;
            p01_reg   <= '0;
            p10_reg   <= '0;
            p11_reg   <= 32'sd65536;
        end else begin
            done_reg <= 1'b0;
            case (step_reg)
                S_IDLE: begin
                    phase_reg <= 1'b0;
                    if (start) begin
                        if (job.command == CMD_INIT) begin
                            tilt_reg <= $signed(job.meas);
                            bias_reg <= '0;
                            p00_reg  <= $signed({8'd0, cfg.initial_covariance});
                            p01_reg  <= '0;
                            p10_reg  <= '0;
                            p11_reg  <= $signed({8'd0, cfg.initial_covariance});
                            step_reg <= S_DONE;
                        end else begin
                            step_reg <= S_RATE;
                        end
                    end
                end
                S_NSE: begin
                    n00_reg  <= sat32(68'(p00_reg) - 68'(t1_reg) + 68'(t2_reg)
                                      + $signed({44'd0, cfg.process_noise}));
                    n01_reg  <= sat32(68'(p01_reg) - 68'(dp11_reg));
                    n10_reg  <= sat32(68'(p10_reg) - 68'(dp11_reg));
                    n11_reg  <= sat32(68'(p11_reg) + $signed({44'd0, cfg.process_noise}));
                    eps_reg  <= sat32(68'($signed(job.meas)) - 68'(apri_reg));
                    step_reg <= S_DIV0;
                end
                S_DIV0, S_DIV1: begin
                    if (!phase_reg) begin
                        phase_reg <= 1'b1;
                    end else if (div_done) begin
                        if (step_reg == S_DIV0) begin
                            k0_reg <= gain_sat(div_q, n00_reg[31]);
                        end else begin
                            k1_reg <= gain_sat(div_q, n10_reg[31]);
                        end
                        phase_reg <= 1'b0;
                        step_reg  <= step_reg + 4'd1;
                    end
                end
                S_DONE: begin
                    done_reg <= 1'b1;
                    step_reg <= S_IDLE;
                end
                default: begin
                    // Multiply steps: the product is registered while phase_reg
                    // is clear and written back once phase_reg is set.
                    if (!phase_reg) begin
                        phase_reg <= 1'b1;
                    end else begin
                        phase_reg <= 1'b0;
                        step_reg  <= step_reg + 4'd1;
                        case (step_reg)
                            S_RATE: rate_reg <= prod_reg[32:0];
                            S_APRI: apri_reg <= 34'(tilt_reg) + rs16[33:0];
                            S_T1:   t1_reg   <= rs16[33:0];
                            S_DP11: dp11_reg <= rs16[32:0];
                            S_T2:   t2_reg   <= rs16[32:0];
                            S_K0E: begin
                                tilt_reg <= 25'(clip(68'(apri_reg) + 68'(rsfb),
                                                     -ANGLE_LIMIT, ANGLE_LIMIT));
                            end
                            S_K1E: begin
                                bias_reg <= 28'(clip(68'(bias_reg) + 68'(rsfb),
                                                     -BIAS_LIMIT, BIAS_LIMIT));
                            end
                            S_K0N0: p00_reg <= sat32(68'(n00_reg) - 68'(rsfb) + clip_w);
                            S_K0N1: p01_reg <= sat32(68'(n01_reg) - 68'(rsfb));
                            S_K1N0: p10_reg <= sat32(68'(n10_reg) - 68'(rsfb));
                            S_K1N1: p11_reg <= sat32(68'(n11_reg) - 68'(rsfb));
                            default: ;
                        endcase
                    end
                end
            endcase
        end
    end

    assign done = done_reg;
    assign tilt = tilt_reg;
    assign bias = bias_reg;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the tilt and gyro bias Kalman filter.
// Depends on ktgb_pkg and kalman_tilt_with_gyro_bias.
`timescale 1ns / 1ps

// The filter prediction is kept in a small class. It holds its own copy of
// the filter state and the registers and queues the expected result beats.
class tilt_scoreboard;
    int unsigned dt_q16;
    int unsigned q_noise;
    int unsigned r_noise;
    int unsigned gyro_fs;
    int unsigned p_init;
    longint angle_q16;
    longint bias_q16;
    longint p_mat[4];
    logic [79:0] pending_results[$];
    int mismatches;
    int atan_deg_q24[16] = '{754974720, 445687602, 235489088, 119537938, 60000934,
                             30029717, 15018523, 7509720, 3754917, 1877466, 938734,
                             469367, 234684, 117342, 58671, 29335};

    function new();
        dt_q16 = 1311;
        q_noise = 1311;
        r_noise = 262144;
        gyro_fs = 250;
        p_init = 65536;
        angle_q16 = 0;
        bias_q16 = 0;
        p_mat = '{65536, 0, 0, 65536};
        mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [23:0] val);
        case (idx)
            ktgb_pkg::REG_STEP_TIME:          dt_q16  = val[15:0];
            ktgb_pkg::REG_PROCESS_NOISE:      q_noise = val;
            ktgb_pkg::REG_MEASUREMENT_NOISE:  r_noise = val;
            ktgb_pkg::REG_GYRO_FULL_SCALE:    gyro_fs = val[10:0];
            ktgb_pkg::REG_INITIAL_COVARIANCE: p_init  = val;
            default: ;
        endcase
    endfunction

    // Round half up, then floor shift.
    function longint rnd(longint v, int s);
        if (s == 0) begin
            return v;
        end
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function longint lim(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint lim32(longint v);
        return lim(v, -64'sd2147483648, 64'sd2147483647);
    endfunction

    // Vectoring CORDIC giving atan2(side, vertical) in Q16.16 degrees.
    function longint accel_angle(logic signed [15:0] side, logic signed [15:0] vert);
        longint x, y, z, base, dx, dy, a;
        y = side;
        x = vert;
        z = 0;
        base = 0;
        if (x < 0) begin
            base = (y >= 0 ? 180 : -180) * 65536;
            x = -x;
            y = -y;
        end
        x = x * (64'sd1 <<< 24);
        y = y * (64'sd1 <<< 24);
        for (int i = 0; i < 16; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            a = rnd(atan_deg_q24[i], 8);
            if (y > 0) begin
                x += dy; y -= dx; z += a;
            end else if (y < 0) begin
                x -= dy; y += dx; z -= a;
            end
        end
        return lim(base + z, -11796480, 11796480);
    endfunction

    function void note_input(logic cmd, logic signed [15:0] side,
                             logic signed [15:0] vert, logic signed [15:0] gyro);
        longint meas, rate, a_pri, dp11, n00, n01, n10, n11, s, k0, k1, eps, d, q;
        logic [79:0] beat;
        meas = accel_angle(side, vert);
        if (cmd == ktgb_pkg::CMD_INIT) begin
            angle_q16 = meas;
            bias_q16 = 0;
            p_mat = '{p_init, 0, 0, p_init};
        end else begin
            d = dt_q16;
            q = q_noise;
            rate = longint'(gyro) * gyro_fs * 2;
            a_pri = angle_q16 + rnd(d * (rate - bias_q16), 16);
            dp11 = rnd(d * p_mat[3], 16);
            n00 = lim32(p_mat[0] - rnd(d * (p_mat[1] + p_mat[2]), 16) + rnd(d * dp11, 16) + q);
            n01 = lim32(p_mat[1] - dp11);
            n10 = lim32(p_mat[2] - dp11);
            n11 = lim32(p_mat[3] + q);
            s = n00 + r_noise;
            if (s < 1) begin
                s = 1;
            end
            k0 = lim32((n00 * 65536) / s);
            k1 = lim32((n10 * 65536) / s);
            eps = lim32(meas - a_pri);
            angle_q16 = lim(a_pri + rnd(k0 * eps, 16), -11796480, 11796480);
            bias_q16 = lim(bias_q16 + rnd(k1 * eps, 16), -131072000, 131072000);
            p_mat[0] = lim32(n00 - rnd(k0 * n00, 16));
            p_mat[1] = lim32(n01 - rnd(k0 * n01, 16));
            p_mat[2] = lim32(n10 - rnd(k1 * n00, 16));
            p_mat[3] = lim32(n11 - rnd(k1 * n01, 16));
        end
        beat = '0;
        beat[24:0] = angle_q16[24:0];
        beat[52:25] = bias_q16[27:0];
        beat[77:53] = meas[24:0];
        pending_results.push_back(beat);
    endfunction

    function void check_result(logic [79:0] got);
        logic [79:0] want;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Unexpected result beat %h", got);
            end
            return;
        end
        want = pending_results.pop_front();
        if (got[24:0] !== want[24:0] || got[52:25] !== want[52:25] ||
            got[77:53] !== want[77:53] || got[79:78] !== want[79:78]) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("Mismatch: angle exp %h got %h, bias exp %h got %h, meas exp %h got %h",
                         want[24:0], got[24:0], want[52:25], got[52:25],
                         want[77:53], got[77:53]);
            end
        end
    endfunction
endclass

module testbench;
    import ktgb_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int STALL_CYCLES = 3000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [23:0] cfg_wdata;

    tilt_scoreboard filter_sb;
    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  stall_req;
    int  stall_left;
    longint cycles;

    kalman_tilt_with_gyro_bias i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog: a run that takes far longer than the slowest correct one fails.
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Receiver. Normally it idles at random; when a long hold-off is requested
    // it holds tready low until its hold-off counter has run out, so that the
    // output register fills and the filter stops taking input beats.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_req) begin
            m_tready <= 1'b0;
            stall_left <= STALL_CYCLES;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Every accepted result beat is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            filter_sb.check_result(m_tdata);
        end
    end

    // Offers one input beat, with random idle cycles before it, and notes it
    // with the scoreboard once the handshake has completed.
    task automatic send_sample(logic cmd, logic [15:0] side, logic [15:0] vert,
                               logic [15:0] gyro);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {gyro, vert, side};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        filter_sb.note_input(cmd, side, vert, gyro);
    endtask

    // Registers are only written with the filter idle: the input is lowered,
    // all results have arrived, and a margin longer than an update has passed.
    task automatic load_registers(logic [23:0] dt, logic [23:0] q, logic [23:0] r,
                                  logic [23:0] fs, logic [23:0] p0);
        logic [23:0] vals[5];
        vals = '{dt, q, r, fs, p0};
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (filter_sb.pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (200) @(posedge aclk);
        for (int i = 0; i < 5; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr <= 3'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
            filter_sb.set_reg(3'(i), vals[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly well-formed runs: an init now and then, updates in between, with
    // either a realistic gyro reading or a full-range one.
    task automatic random_run(int n);
        logic cmd;
        logic [15:0] gyro;
        for (int i = 0; i < n; i++) begin
            cmd = ($urandom_range(99) < 10) ? CMD_INIT : CMD_UPDATE;
            if ($urandom_range(1)) begin
                gyro = 16'($signed($urandom_range(400)) - 200);
            end else begin
                gyro = 16'($urandom);
            end
            send_sample(cmd, 16'($urandom), 16'($urandom), gyro);
        end
    endtask

    initial begin
        filter_sb = new();
        tx_idle_pct = 20;
        rx_idle_pct = 49;
        stall_req = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_INIT;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed beats: the zero vector, the left half plane on both sides
        // of the axis, the extreme counts, and updates at full gyro rate.
        send_sample(CMD_UPDATE, 16'h0000, 16'h0000, 16'h0000);
        send_sample(CMD_INIT,   16'h0000, 16'h0000, 16'h0000);
        send_sample(CMD_INIT,   16'h0000, 16'hFFFB, 16'h0000);
        send_sample(CMD_UPDATE, 16'h0001, 16'h8000, 16'h7FFF);
        send_sample(CMD_UPDATE, 16'hFFFF, 16'h8000, 16'h8000);
        send_sample(CMD_INIT,   16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(CMD_UPDATE, 16'h8000, 16'h8000, 16'h8000);
        send_sample(CMD_UPDATE, 16'h8000, 16'h7FFF, 16'h7FFF);
        send_sample(CMD_UPDATE, 16'h7FFF, 16'h8000, 16'h0000);
        send_sample(CMD_UPDATE, 16'h0000, 16'h7FFF, 16'hFFFF);
        send_sample(CMD_UPDATE, 16'h8000, 16'h0000, 16'h0001);
        send_sample(CMD_UPDATE, 16'h7FFF, 16'h0000, 16'h7FFF);
        send_sample(CMD_INIT,   16'h8000, 16'hFFFF, 16'h8000);
        send_sample(CMD_UPDATE, 16'h4000, 16'h4000, 16'h0100);
        random_run(240);

        // Upper extremes of every register, with a long receiver hold-off.
        load_registers(24'd65535, 24'd16777215, 24'd16777215, 24'd2000, 24'd16777215);
        stall_req <= 1'b1;
        @(posedge aclk);
        stall_req <= 1'b0;
        random_run(255);

        // Lower extremes.
        tx_idle_pct = 49;
        rx_idle_pct = 20;
        load_registers(24'd1, 24'd0, 24'd1, 24'd1, 24'd0);
        random_run(255);

        // A frozen prediction and no measurement noise, so that the
        // innovation variance is the predicted covariance alone.
        load_registers(24'd0, 24'd1311, 24'd0, 24'd250, 24'd0);
        random_run(255);

        // Random settings within range, then no idling at all.
        load_registers(24'($urandom_range(65535, 1)), 24'($urandom_range(16777215)),
                       24'($urandom_range(16777215, 1)), 24'($urandom_range(2000, 1)),
                       24'($urandom_range(16777215)));
        random_run(270);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_registers(24'($urandom_range(2000, 1)), 24'($urandom_range(5000)),
                       24'($urandom_range(1000000, 1)), 24'($urandom_range(2000, 1)),
                       24'($urandom_range(200000)));
        random_run(270);

        s_tvalid <= 1'b0;
        while (filter_sb.pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (300) @(posedge aclk);
        if (filter_sb.mismatches == 0 && filter_sb.pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+sv
sv/ktgb_pkg.sv
sv/ktgb_cordic.sv
sv/ktgb_div.sv
sv/ktgb_filter.sv
sv/kalman_tilt_with_gyro_bias.sv
tb/testbench.sv
